// ===== sv/romberg_integration_macros.svh =====
// Assertion macros used by the checker file of the romberg integration block
`ifndef ROMBERG_INTEGRATION_MACROS_SVH
`define ROMBERG_INTEGRATION_MACROS_SVH

// same-cycle implication, sampled on clock, quiet during reset
`define RMB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, quiet during reset
`define RMB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rmb_pkg.sv =====
// Shared types and constants of the romberg integration block
`timescale 1ns / 1ps
package rmb_pkg;
   localparam int IDX_WIDTH     = 5;
   localparam int INTERVAL_BITS = 47;
   localparam int SUM_BITS      = 64;
   localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 47'd16777216;
   localparam logic [IDX_WIDTH-1:0]     LEVELS_RESET   = 5'd16;

   typedef enum logic {
      CSR_INTERVAL_WIDTH = 1'b0,
      CSR_LEVELS_IN_USE  = 1'b1
   } csr_index_type;

   // one estimate moving between units
   typedef struct packed {
      logic valid;
      logic sat;
   } token_type;
endpackage

// ===== sv/rmb_cell.sv =====
// One Richardson column cell: holds last row's entry, divides the difference, passes it on
`timescale 1ns / 1ps
module rmb_cell #(
   parameter int VALUE_WIDTH = 48,
   parameter int COLUMN      = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rmb_pkg::IDX_WIDTH-1:0]     rows,
   input  rmb_pkg::token_type                tok_i,
   input  logic [VALUE_WIDTH-1:0]            val_i,
   output rmb_pkg::token_type                tok_o,
   output logic [VALUE_WIDTH-1:0]            val_o,
   output logic                              row_done,
   output logic [VALUE_WIDTH-1:0]            prev_o,
   input  logic                              shift,
   input  logic [VALUE_WIDTH-1:0]            emit_val_i,
   input  logic                              emit_sat_i,
   output logic [VALUE_WIDTH-1:0]            emit_val_o,
   output logic                              emit_sat_o
);
   import rmb_pkg::*;

   localparam int W  = VALUE_WIDTH;
   // the divisor is 2^N - 1
   localparam int N  = 2 * (COLUMN + 1);
   localparam int NS = (N >= W + 1) ? 0 : W + 1 - N;
   localparam logic [W:0] LOW_MASK = {(W+1){1'b1}} >> NS;
   localparam int DW = ((N > W + 1) ? N : W + 1) + 1;
   localparam logic [DW-1:0] DIVISOR = {DW{1'b1}} >> (DW - N);
   localparam logic [IDX_WIDTH-1:0] COL_NUM = IDX_WIDTH'(COLUMN + 1);

   logic [W-1:0]    prev_ff, base_ff, out_val_ff, emit_val_ff;
   logic            neg_ff, busy_ff, emit_sat_ff;
   logic [W:0]      mag_ff, quo_ff;
   token_type       tok_ff;

   logic [W:0]      diff_in, hi, lo, quo_rnd;
   logic [DW-1:0]   rem_w, rem_fin;
   logic            exact, round_up, finish, sat_hi, sat_lo;
   logic [W+1:0]    corr, total;
   logic [W-1:0]    res_in;

   always_comb begin
      diff_in  = {val_i[W-1], val_i} - {prev_ff[W-1], prev_ff};
      // a*2^N + b = a*(2^N - 1) + (a + b): fold the high part onto the low part
      hi       = mag_ff >> N;
      lo       = mag_ff & LOW_MASK;
      rem_w    = DW'(mag_ff);
      exact    = rem_w == DIVISOR;
      rem_fin  = exact ? '0 : rem_w;
      round_up = {rem_fin[DW-2:0], 1'b0} >= DIVISOR;
      quo_rnd  = quo_ff + {{W{1'b0}}, exact} + {{W{1'b0}}, round_up};
      finish   = busy_ff && !tok_i.valid && (hi == '0);
      corr     = neg_ff ? -{1'b0, quo_rnd} : {1'b0, quo_rnd};
      total    = {base_ff[W-1], base_ff[W-1], base_ff} + corr;
      sat_hi   = !total[W+1] && (total[W:W-1] != 2'b00);
      sat_lo   = total[W+1] && (total[W:W-1] != 2'b11);
      if (sat_hi) begin
         res_in = {1'b0, {(W-1){1'b1}}};
      end else if (sat_lo) begin
         res_in = {1'b1, {(W-1){1'b0}}};
      end else begin
         res_in = total[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         tok_ff  <= '0;
      end else begin
         tok_ff <= '{valid: finish, sat: sat_hi | sat_lo};
         if (tok_i.valid) begin
            prev_ff <= val_i;
            base_ff <= val_i;
            neg_ff  <= diff_in[W];
            mag_ff  <= diff_in[W] ? -diff_in : diff_in;
            quo_ff  <= '0;
            busy_ff <= COL_NUM < rows;
         end else if (busy_ff) begin
            if (hi != '0) begin
               quo_ff <= quo_ff + hi;
               mag_ff <= hi + lo;
            end else begin
               busy_ff    <= 1'b0;
               out_val_ff <= res_in;
            end
         end
      end
   end

   // load the row entry when it arrives, slide toward column one while emitting
   always_ff @(posedge clock) begin
      if (tok_i.valid) begin
         emit_val_ff <= val_i;
         emit_sat_ff <= tok_i.sat;
      end else if (shift) begin
         emit_val_ff <= emit_val_i;
         emit_sat_ff <= emit_sat_i;
      end
   end

   assign tok_o      = tok_ff;
   assign val_o      = out_val_ff;
   assign row_done   = tok_i.valid && (COL_NUM == rows);
   assign prev_o     = prev_ff;
   assign emit_val_o = emit_val_ff;
   assign emit_sat_o = emit_sat_ff;
endmodule

// ===== sv/rmb_scale.sv =====
// Bit-serial multiply by the step width, round and saturate: forms the first column
`timescale 1ns / 1ps
module rmb_scale #(
   parameter int VALUE_WIDTH   = 48,
   parameter int FRACTION_BITS = 24,
   parameter int MCAND_BITS    = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [MCAND_BITS-1:0]               mcand_i,
   input  logic [MCAND_BITS+rmb_pkg::INTERVAL_BITS+1:0] init_i,
   input  logic [rmb_pkg::INTERVAL_BITS-1:0]   step_i,
   output rmb_pkg::token_type                  tok_o,
   output logic [VALUE_WIDTH-1:0]              val_o
);
   import rmb_pkg::*;

   localparam int W    = VALUE_WIDTH;
   localparam int AW   = MCAND_BITS + INTERVAL_BITS + 2;
   localparam int CNTW = $clog2(INTERVAL_BITS + 1);
   localparam logic [CNTW-1:0] STEPS = CNTW'(INTERVAL_BITS);

   logic [AW-1:0]            acc_ff, mc_ff;
   logic [INTERVAL_BITS-1:0] h_ff;
   logic [CNTW-1:0]          cnt_ff;
   logic                     busy_ff;
   token_type                tok_ff;
   logic [W-1:0]             val_ff;

   logic [AW-1:0] rnd, shr;
   logic          fits, finish;
   logic [W-1:0]  val_in;

   always_comb begin
      rnd    = acc_ff + (AW'(1) << FRACTION_BITS);
      shr    = AW'($signed(rnd) >>> (FRACTION_BITS + 1));
      fits   = (&shr[AW-1:W-1]) || !(|shr[AW-1:W-1]);
      finish = busy_ff && !start && (cnt_ff == '0);
      if (fits) begin
         val_in = shr[W-1:0];
      end else if (shr[AW-1]) begin
         val_in = {1'b1, {(W-1){1'b0}}};
      end else begin
         val_in = {1'b0, {(W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         tok_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         tok_ff <= '{valid: finish, sat: !fits};
         if (start) begin
            acc_ff  <= init_i;
            mc_ff   <= AW'($signed(mcand_i));
            h_ff    <= step_i;
            cnt_ff  <= STEPS;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               acc_ff <= acc_ff + (h_ff[0] ? mc_ff : '0);
               mc_ff  <= {mc_ff[AW-2:0], 1'b0};
               h_ff   <= h_ff >> 1;
               cnt_ff <= cnt_ff - 1'b1;
            end else begin
               busy_ff <= 1'b0;
               val_ff  <= val_in;
            end
         end
      end
   end

   assign tok_o = tok_ff;
   assign val_o = val_ff;
endmodule

// ===== sv/romberg_integration.sv =====
// Romberg integration engine: sample intake, row sequencing and the chain of column cells
//
// Samples arrive in Romberg order (f(a), f(b), then the midpoints of each new row) on req_,
// one per cycle while a row is being summed. At the end of a row the block stops taking
// samples: the first-column estimate comes from a bit-serial multiply by the step width,
// then the Richardson columns ripple down a chain of cells, the cell for column j dividing
// by 4^(j-1)-1 by folding the high part of the difference onto its low part. When row i
// is complete its i entries leave on rsp_ one per accepted transfer. interval_width is
// sampled when f(a) is taken; levels_in_use is clamped to 2..MAX_LEVELS. Values are signed
// fixed point with FRACTION_BITS fraction bits and saturate; rsp_tuser flags a clipped
// entry. No clearing pass follows reset.
`timescale 1ns / 1ps
module romberg_integration #(
   parameter int MAX_LEVELS    = 16,
   parameter int VALUE_WIDTH   = 48,
   parameter int FRACTION_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // sample_value
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // row_index, column_index, estimate
   output logic [((VALUE_WIDTH+10+7)/8)*8-1:0]    rsp_tdata,
   output logic                                   rsp_tlast,
   // saturated
   output logic                                   rsp_tuser,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  rmb_pkg::csr_index_type                 csr_index,
   input  logic [rmb_pkg::INTERVAL_BITS-1:0]      csr_data
);
   import rmb_pkg::*;

   localparam int W     = VALUE_WIDTH;
   localparam int MW    = (W + 1 > SUM_BITS) ? W + 1 : SUM_BITS;
   localparam int AW    = MW + INTERVAL_BITS + 2;
   localparam int CW    = MAX_LEVELS - 1;
   localparam int OUT_W = ((W + 10 + 7) / 8) * 8;
   localparam logic [IDX_WIDTH-1:0] MAX_IDX = IDX_WIDTH'(MAX_LEVELS);
   localparam logic [IDX_WIDTH-1:0] MIN_IDX = IDX_WIDTH'(2);

   typedef enum logic [1:0] {S_TAKE, S_SCALE, S_CHAIN, S_EMIT} state_type;

   state_type                 state_ff;
   logic [INTERVAL_BITS-1:0]  interval_ff, step_ff;
   logic [IDX_WIDTH-1:0]      levels_ff, level_ff, rows_ff, col_ff;
   logic [CW-1:0]             cnt_ff;
   logic [SUM_BITS-1:0]       sum_ff;
   logic [W-1:0]              first_ff;

   logic [W-1:0]              x;
   logic [SUM_BITS-1:0]       sum_in;
   logic [CW-1:0]             cnt_in, target;
   logic                      take, row1_end, rowk_end, start, rsp_fire, row_over, any_done;
   logic [MW-1:0]             mcand;
   logic [AW-1:0]             init;
   logic [IDX_WIDTH-1:0]      lim;

   token_type                 tok_c  [0:MAX_LEVELS];
   logic [W-1:0]              val_c  [0:MAX_LEVELS];
   logic [W-1:0]              ev_c   [0:MAX_LEVELS];
   logic                      es_c   [0:MAX_LEVELS];
   logic [W-1:0]              prev_c [0:MAX_LEVELS-1];
   logic [MAX_LEVELS-1:0]     done_c;

   assign x          = req_tdata[W-1:0];
   assign req_tready = state_ff == S_TAKE;
   assign take       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      sum_in   = sum_ff + SUM_BITS'($signed(x));
      cnt_in   = cnt_ff + 1'b1;
      target   = CW'(1) << (level_ff - MIN_IDX);
      row1_end = take && (level_ff <= IDX_WIDTH'(1)) && (cnt_ff != '0);
      rowk_end = take && (level_ff > IDX_WIDTH'(1)) && (cnt_in == target);
      start    = row1_end || rowk_end;
      if (level_ff <= IDX_WIDTH'(1)) begin
         mcand = MW'($signed(first_ff)) + MW'($signed(x));
         init  = '0;
      end else begin
         mcand = MW'($signed(sum_in));
         init  = AW'($signed(prev_c[0])) << FRACTION_BITS;
      end
      if (levels_ff < MIN_IDX) begin
         lim = MIN_IDX;
      end else if (levels_ff > MAX_IDX) begin
         lim = MAX_IDX;
      end else begin
         lim = levels_ff;
      end
      rsp_fire = rsp_tvalid && rsp_tready;
      row_over = rsp_fire && (col_ff == rows_ff);
      any_done = |done_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_TAKE;
         interval_ff <= INTERVAL_RESET;
         levels_ff   <= LEVELS_RESET;
         step_ff     <= INTERVAL_RESET;
         level_ff    <= IDX_WIDTH'(1);
         cnt_ff      <= '0;
         sum_ff      <= '0;
         first_ff    <= '0;
         rows_ff     <= '0;
         col_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_INTERVAL_WIDTH: interval_ff <= csr_data;
               CSR_LEVELS_IN_USE:  levels_ff   <= csr_data[IDX_WIDTH-1:0];
               default:            levels_ff   <= levels_ff;
            endcase
         end
         unique case (state_ff)
            S_TAKE: begin
               if (take) begin
                  if (level_ff <= IDX_WIDTH'(1)) begin
                     if (cnt_ff == '0) begin
                        first_ff <= x;
                        step_ff  <= interval_ff;
                        cnt_ff   <= CW'(1);
                     end else begin
                        rows_ff  <= IDX_WIDTH'(1);
                        state_ff <= S_SCALE;
                     end
                  end else begin
                     sum_ff <= sum_in;
                     cnt_ff <= cnt_in;
                     if (rowk_end) begin
                        rows_ff  <= level_ff;
                        state_ff <= S_SCALE;
                     end
                  end
               end
            end
            S_SCALE: begin
               // a one-entry row is complete as soon as the first column arrives
               if (any_done) begin
                  col_ff   <= IDX_WIDTH'(1);
                  state_ff <= S_EMIT;
               end else if (tok_c[0].valid) begin
                  state_ff <= S_CHAIN;
               end
            end
            S_CHAIN: begin
               if (any_done) begin
                  col_ff   <= IDX_WIDTH'(1);
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (rsp_fire) col_ff <= col_ff + 1'b1;
               if (row_over) begin
                  state_ff <= S_TAKE;
                  cnt_ff   <= '0;
                  sum_ff   <= '0;
                  if (rows_ff >= MIN_IDX) step_ff <= step_ff >> 1;
                  level_ff <= (rows_ff >= lim) ? IDX_WIDTH'(1) : rows_ff + 1'b1;
               end
            end
            default: state_ff <= S_TAKE;
         endcase
      end
   end

   rmb_scale #(
      .VALUE_WIDTH   (W),
      .FRACTION_BITS (FRACTION_BITS),
      .MCAND_BITS    (MW)
   ) u_scale (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .mcand_i (mcand),
      .init_i  (init),
      .step_i  (step_ff),
      .tok_o   (tok_c[0]),
      .val_o   (val_c[0])
   );

   assign ev_c[MAX_LEVELS] = '0;
   assign es_c[MAX_LEVELS] = 1'b0;

   for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
      rmb_cell #(
         .VALUE_WIDTH (W),
         .COLUMN      (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .rows       (rows_ff),
         .tok_i      (tok_c[k]),
         .val_i      (val_c[k]),
         .tok_o      (tok_c[k+1]),
         .val_o      (val_c[k+1]),
         .row_done   (done_c[k]),
         .prev_o     (prev_c[k]),
         .shift      (rsp_fire),
         .emit_val_i (ev_c[k+1]),
         .emit_sat_i (es_c[k+1]),
         .emit_val_o (ev_c[k]),
         .emit_sat_o (es_c[k])
      );
   end

   assign rsp_tvalid = state_ff == S_EMIT;
   assign rsp_tdata  = OUT_W'({ev_c[0], col_ff, rows_ff});
   assign rsp_tlast  = col_ff == rows_ff;
   assign rsp_tuser  = es_c[0];
endmodule

// ===== sv/rmb_checker.sv =====
// Port-level checks of the romberg integration block, bound to the top level
`timescale 1ns / 1ps
`include "romberg_integration_macros.svh"
module rmb_checker #(
   parameter int VALUE_WIDTH = 48
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((VALUE_WIDTH+10+7)/8)*8-1:0] rsp_tdata,
   input logic                                rsp_tlast
);
   `RMB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped or changed while stalled")
   `RMB_ASSERT_NOW(a_no_take_while_emit, rsp_tvalid, !req_tready, "sample taken while a row is being emitted")
   `RMB_ASSERT_NOW(a_col_range, rsp_tvalid, (rsp_tdata[9:5] != 5'd0) && (rsp_tdata[9:5] <= rsp_tdata[4:0]), "column outside its row")
   `RMB_ASSERT_NOW(a_last_col, rsp_tvalid && rsp_tlast, rsp_tdata[9:5] == rsp_tdata[4:0], "row end on wrong column")
endmodule

bind romberg_integration rmb_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_rmb_checker (.*);

// ===== tb/sv/romberg_integration_test.sv =====
// Self-checking testbench of romberg_integration: random handshakes, row-by-row estimate check
`timescale 1ns / 1ps
module romberg_integration_test;
   import rmb_pkg::*;

   localparam int LEVELS     = 16;
   localparam int VW         = 48;
   localparam int FRAC       = 24;
   localparam int QUIET_MAX  = 20000;
   localparam int SETTLE_CYC = 1000;

   localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
   localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic [INTERVAL_BITS-1:0] WIDTH_MAX = {INTERVAL_BITS{1'b1}};

   typedef struct {
      logic [4:0]          row;
      logic [4:0]          col;
      logic signed [VW-1:0] est;
      logic                last;
      logic                sat;
   } entry_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_INTERVAL_WIDTH;
   logic [INTERVAL_BITS-1:0] csr_data = '0;

   logic signed [VW-1:0] sample_queue[$];
   entry_t               estimate_queue[$];
   int                   failures = 0;
   int                   quiet_cycles = 0;

   // mirror of the engine
   logic [INTERVAL_BITS-1:0] width_reg;
   logic [4:0]               level_reg;
   logic signed [VW-1:0]     prior_row[LEVELS];
   logic signed [VW-1:0]     fresh_row[LEVELS];
   logic                     fresh_sat[LEVELS];
   logic signed [63:0]       mid_sum;
   logic [VW-1:0]            step_w;
   int                       taken;
   int                       cur_level;
   logic signed [VW-1:0]     fa_hold;

   romberg_integration uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata),    // sample_value
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),    // row_index, column_index, estimate
      .rsp_tlast(rsp_tlast),    // row_last
      .rsp_tuser(rsp_tuser),    // saturated
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // round to nearest (ties up) after an arithmetic shift, then clip
   function automatic logic signed [VW-1:0] round_clip(input logic signed [127:0] w,
                                                       input int sh, output logic sat);
      logic signed [127:0] lo_lim;
      logic signed [127:0] hi_lim;
      lo_lim = VAL_MIN;
      hi_lim = VAL_MAX;
      if (sh > 0) w = (w + (128'sd1 <<< (sh - 1))) >>> sh;
      sat = 1'b1;
      if (w < lo_lim) return VAL_MIN;
      if (w > hi_lim) return VAL_MAX;
      sat = 1'b0;
      return w[VW-1:0];
   endfunction

   // (a - b) / d, to nearest, ties away from zero
   function automatic logic signed [127:0] richardson_step(input logic signed [VW-1:0] a,
                                                          input logic signed [VW-1:0] b,
                                                          input logic signed [127:0] d);
      logic signed [127:0] diff;
      logic signed [127:0] mag;
      logic signed [127:0] q;
      logic signed [127:0] r;
      diff = a;
      diff = diff - b;
      mag = (diff < 0) ? -diff : diff;
      q = mag / d;
      r = mag % d;
      if (r >= d - r) q = q + 1;
      return (diff < 0) ? -q : q;
   endfunction

   task automatic integrate_sample(input logic signed [VW-1:0] x);
      logic signed [127:0] t;
      logic signed [127:0] ta;
      logic signed [127:0] tb;
      logic signed [127:0] d;
      int rows;
      int lim;
      entry_t e;
      tb = {80'd0, step_w};
      if (cur_level <= 1) begin
         if (taken == 0) begin
            fa_hold = x;
            step_w = {1'b0, width_reg};
            taken = 1;
            return;
         end
         ta = fa_hold;
         t = ta * tb;
         ta = x;
         t = t + ta * tb;
         fresh_row[0] = round_clip(t, FRAC + 1, fresh_sat[0]);
         rows = 1;
      end else begin
         mid_sum = mid_sum + x;
         taken++;
         if (taken < (1 << (cur_level - 2))) return;
         rows = cur_level;
         ta = prior_row[0];
         t = ta <<< FRAC;
         ta = mid_sum;
         t = t + ta * tb;
         fresh_row[0] = round_clip(t, FRAC + 1, fresh_sat[0]);
         for (int j = 1; j < rows; j++) begin
            d = (128'sd1 <<< (2 * j)) - 1;
            t = fresh_row[j-1];
            t = t + richardson_step(fresh_row[j-1], prior_row[j-1], d);
            fresh_row[j] = round_clip(t, 0, fresh_sat[j]);
         end
         step_w = step_w >> 1;
      end
      for (int j = 0; j < rows; j++) begin
         e.row  = 5'(rows);
         e.col  = 5'(j + 1);
         e.est  = fresh_row[j];
         e.last = (j + 1 == rows);
         e.sat  = fresh_sat[j];
         estimate_queue.push_back(e);
         prior_row[j] = fresh_row[j];
      end
      lim = level_reg;
      if (lim < 2) lim = 2;
      if (lim > LEVELS) lim = LEVELS;
      taken = 0;
      mid_sum = 0;
      cur_level = (rows >= lim) ? 1 : rows + 1;
   endtask

   // sample driver
   int  send_gap = 0;
   logic send_burst = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req_tdata <= {16'd0, sample_queue.pop_front()};
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 30) == 0) send_burst <= ~send_burst;
            send_gap <= send_burst ? 0 : $urandom_range(0, 18);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver stalls
   int  recv_stall = 0;
   logic recv_burst = 1'b0;
   always @(posedge clock) begin
      int draw;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         if ($urandom_range(0, 30) == 0) recv_burst <= ~recv_burst;
         draw = recv_burst ? 0 : $urandom_range(0, 18);
         recv_stall <= draw;
         rsp_tready <= (draw == 0);
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_tready <= (recv_stall == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: mirror register writes, predict on every sample, check every entry
   always @(posedge clock) begin
      entry_t want;
      if (reset) begin
         width_reg = INTERVAL_RESET;
         level_reg = LEVELS_RESET;
         step_w = {1'b0, INTERVAL_RESET};
         mid_sum = 0;
         taken = 0;
         cur_level = 1;
         fa_hold = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_INTERVAL_WIDTH) width_reg = csr_data;
            else level_reg = csr_data[4:0];
         end
         if (req_tvalid && req_tready) integrate_sample(req_tdata[VW-1:0]);
         if (rsp_tvalid && rsp_tready) begin
            if (estimate_queue.size() == 0) begin
               $display("%0t: unexpected entry row %0d col %0d estimate %0d", $time,
                        rsp_tdata[4:0], rsp_tdata[9:5], $signed(rsp_tdata[57:10]));
               failures++;
            end else begin
               want = estimate_queue.pop_front();
               if (rsp_tdata[4:0] !== want.row || rsp_tdata[9:5] !== want.col ||
                   rsp_tdata[57:10] !== want.est || rsp_tlast !== want.last ||
                   rsp_tuser !== want.sat) begin
                  $display("%0t: expected row %0d col %0d est %0d last %0b sat %0b", $time,
                           want.row, want.col, want.est, want.last, want.sat);
                  $display("%0t: actual   row %0d col %0d est %0d last %0b sat %0b", $time,
                           rsp_tdata[4:0], rsp_tdata[9:5], $signed(rsp_tdata[57:10]),
                           rsp_tlast, rsp_tuser);
                  failures++;
               end
            end
         end
      end
   end

   // watchdog on transfer-free stretches
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [INTERVAL_BITS-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // drain every expected entry, then give the engine time to go quiet
   task automatic settle();
      do @(posedge clock);
      while (sample_queue.size() > 0 || req_tvalid || estimate_queue.size() > 0);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   function automatic logic signed [VW-1:0] draw_sample();
      logic signed [VW-1:0] v;
      case ($urandom_range(0, 6))
         0: v = VAL_MIN;
         1: v = VAL_MAX;
         2: v = 0;
         3, 4: v = VW'({$urandom, $urandom});
         default: v = $signed($urandom_range(0, 1 << 27)) - (1 << 26);
      endcase
      return v;
   endfunction

   initial begin
      int sent;
      int n;
      logic [INTERVAL_BITS-1:0] w;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // one full four-row integral over a unit interval with extreme samples
      write_reg(CSR_LEVELS_IN_USE, 5'd4);
      write_reg(CSR_INTERVAL_WIDTH, INTERVAL_RESET);
      sample_queue = '{VAL_MIN, VAL_MAX, 48'sd0, -48'sd1, 48'sd1, VAL_MAX, VAL_MIN,
                       48'sd3 <<< 24, -(48'sd5 <<< 23)};
      settle();
      // widest interval, level count above range: four rows, clipping expected
      write_reg(CSR_INTERVAL_WIDTH, WIDTH_MAX);
      write_reg(CSR_LEVELS_IN_USE, 5'd31);
      sample_queue = '{VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN,
                       48'sd1 <<< 24, 48'sd1 <<< 24, 48'sd1 <<< 24, 48'sd1 <<< 24};
      settle();
      // lower the level count below the current row: the integral closes after row five
      write_reg(CSR_LEVELS_IN_USE, 5'd1);
      repeat (8) sample_queue.push_back(draw_sample());
      settle();
      // zero interval, level count zero acts as two
      write_reg(CSR_INTERVAL_WIDTH, '0);
      write_reg(CSR_LEVELS_IN_USE, 5'd0);
      sample_queue = '{VAL_MAX, VAL_MIN, 48'sd7 <<< 24};
      settle();

      sent = 0;
      while (sent < 120) begin
         case ($urandom_range(0, 5))
            0: w = '0;
            1: w = WIDTH_MAX;
            2: w = INTERVAL_RESET;
            3: w = INTERVAL_BITS'({$urandom, $urandom});
            default: w = $urandom_range(1, 1 << 28);
         endcase
         write_reg(CSR_INTERVAL_WIDTH, w);
         if ($urandom_range(0, 5) == 0) write_reg(CSR_LEVELS_IN_USE, $urandom_range(0, 31));
         else write_reg(CSR_LEVELS_IN_USE, $urandom_range(2, 7));
         n = $urandom_range(1, 20);
         repeat (n) sample_queue.push_back(draw_sample());
         sent += n;
         settle();
      end

      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

// ===== romberg_integration.f =====
+incdir+sv
sv/rmb_pkg.sv
sv/rmb_cell.sv
sv/rmb_scale.sv
sv/romberg_integration.sv
sv/rmb_checker.sv
tb/sv/romberg_integration_test.sv
